// File: rtl/core/vls_pkg.sv
// ----------------------------------------------------------------------------
// vls_pkg
// shared types and constants for the voxel line-of-sight block
// ----------------------------------------------------------------------------
package vls_pkg;

   // view range register
   localparam int unsigned DIST_W = 14;
   localparam logic [DIST_W-1:0] DIST_RESET = 14'd4096;

   // request type codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // query answer from the tracer
   typedef struct packed {
      logic valid;
      logic visible;
   } vls_rsp_type;

endpackage

// File: rtl/core/vls_occ_mem.sv
// ----------------------------------------------------------------------------
// vls_occ_mem
// occupancy bitmap, one row per (z,y) holding all x bits, with clear pass
// ----------------------------------------------------------------------------
module vls_occ_mem #(
   parameter int unsigned G = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [2*G-1:0]    rd_row,
   output logic [(1<<G)-1:0] rd_data,
   input  logic              wr_en,
   input  logic [2*G-1:0]    wr_row,
   input  logic [(1<<G)-1:0] wr_data,
   output logic              ready
);

   localparam int unsigned ROWS = 1 << (2*G);
   localparam int unsigned SIDE = 1 << G;

   logic [SIDE-1:0] mem [ROWS];
   logic [SIDE-1:0] rd_data_ff;
   logic [2*G-1:0]  clr_ff;
   logic [2*G-1:0]  clr_in;
   logic            clearing_ff;
   logic            clearing_in;

   always_comb begin
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == (2*G)'(ROWS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_ff      <= clr_in;
         clearing_ff <= clearing_in;
      end
   end

   // one write and one registered read per cycle; the clear pass takes the write port while it runs
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clearing_ff;

endmodule

// File: rtl/core/vls_tracer.sv
// ----------------------------------------------------------------------------
// vls_tracer
// query setup on a shared multiplier, then cell by cell dda walk
// ----------------------------------------------------------------------------
module vls_tracer #(
   parameter int unsigned G = 5,
   parameter int unsigned F = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [2:0][G+F-1:0]          pt_s,
   input  logic [2:0][G+F-1:0]          pt_e,
   input  logic [vls_pkg::DIST_W-1:0]   max_dist,
   output logic                         rd_en,
   output logic [2*G-1:0]               rd_row,
   input  logic [(1<<G)-1:0]            rd_data,
   output vls_pkg::vls_rsp_type         rsp
);

   localparam int unsigned CB  = G + F;
   localparam int unsigned NW  = CB + 1;
   localparam int unsigned MW  = (NW > vls_pkg::DIST_W) ? NW : vls_pkg::DIST_W;
   localparam int unsigned PW  = 2 * MW;
   localparam int unsigned CW  = PW + 1;
   localparam int unsigned SW  = PW + 2;
   localparam int unsigned CLW = G + 2;
   localparam logic [NW-1:0] ONE = NW'(1) << F;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_TEST  = 3'd4;

   // product sequence
   localparam logic [3:0] P_SQX  = 4'd0;
   localparam logic [3:0] P_SQY  = 4'd1;
   localparam logic [3:0] P_SQZ  = 4'd2;
   localparam logic [3:0] P_MAX  = 4'd3;
   localparam logic [3:0] P_N0M1 = 4'd4;
   localparam logic [3:0] P_N1M0 = 4'd5;
   localparam logic [3:0] P_N0M2 = 4'd6;
   localparam logic [3:0] P_N2M0 = 4'd7;
   localparam logic [3:0] P_N1M2 = 4'd8;
   localparam logic [3:0] P_N2M1 = 4'd9;
   localparam logic [3:0] P_DONE = 4'd10;

   logic [2:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [3:0] tag_ff;
   logic       pv_ff;

   logic [2:0][CB-1:0]  mag_ff, mag_in;
   logic [2:0][NW-1:0]  num_ff, num_in;
   logic [2:0]          pos_ff, pos_in;
   logic [2:0]          nz_ff, nz_in;
   logic [2:0][G-1:0]   scell_ff, scell_in;
   logic [2:0][G-1:0]   fin_ff, fin_in;
   logic [2:0][CLW-1:0] cell_ff, cell_in;

   logic [SW-1:0]        d2_ff, d2_in;
   logic [PW-1:0]        msq_ff, msq_in;
   logic signed [CW-1:0] c01_ff, c01_in;
   logic signed [CW-1:0] c02_ff, c02_in;
   logic signed [CW-1:0] c12_ff, c12_in;

   logic [MW-1:0] mul_a, mul_b;
   logic [PW-1:0] prod_ff;
   logic signed [CW-1:0] prod_s;

   vls_pkg::vls_rsp_type rsp_ff, rsp_in;

   logic [2:0][CW-1:0] shm;
   logic               at_end, at_start, in_grid, blocked;
   logic               b01, b02, b12;
   logic [1:0]         ax;
   logic [NW-1:0]      n_sel;
   logic [CB-1:0]      m_sel;

   assign prod_s = $signed({1'b0, prod_ff});

   // operands for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cnt_ff)
         P_SQX:  begin mul_a = MW'(mag_ff[0]); mul_b = MW'(mag_ff[0]); end
         P_SQY:  begin mul_a = MW'(mag_ff[1]); mul_b = MW'(mag_ff[1]); end
         P_SQZ:  begin mul_a = MW'(mag_ff[2]); mul_b = MW'(mag_ff[2]); end
         P_MAX:  begin mul_a = MW'(max_dist);  mul_b = MW'(max_dist);  end
         P_N0M1: begin mul_a = MW'(num_ff[0]); mul_b = MW'(mag_ff[1]); end
         P_N1M0: begin mul_a = MW'(num_ff[1]); mul_b = MW'(mag_ff[0]); end
         P_N0M2: begin mul_a = MW'(num_ff[0]); mul_b = MW'(mag_ff[2]); end
         P_N2M0: begin mul_a = MW'(num_ff[2]); mul_b = MW'(mag_ff[0]); end
         P_N1M2: begin mul_a = MW'(num_ff[1]); mul_b = MW'(mag_ff[2]); end
         P_N2M1: begin mul_a = MW'(num_ff[2]); mul_b = MW'(mag_ff[1]); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // walk helpers
   always_comb begin
      at_end   = 1'b1;
      at_start = 1'b1;
      in_grid  = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (cell_ff[i] != {2'b00, fin_ff[i]})   at_end   = 1'b0;
         if (cell_ff[i] != {2'b00, scell_ff[i]}) at_start = 1'b0;
         if (cell_ff[i][CLW-1:CLW-2] != 2'b00)   in_grid  = 1'b0;
         shm[i] = {{(CW-CB-F){1'b0}}, mag_ff[i], {F{1'b0}}};
      end
      blocked = in_grid && !at_start && rd_data[cell_ff[0][G-1:0]];
      // strict earlier crossing, zero delta never crosses
      b01 = nz_ff[0] && (!nz_ff[1] || (c01_ff < 0));
      b02 = nz_ff[0] && (!nz_ff[2] || (c02_ff < 0));
      b12 = nz_ff[1] && (!nz_ff[2] || (c12_ff < 0));
      if (b01 && b02)  ax = 2'd0;
      else if (b12)    ax = 2'd1;
      else             ax = 2'd2;
      n_sel = num_ff[ax];
      m_sel = mag_ff[ax];
   end

   assign rd_row = {cell_ff[2][G-1:0], cell_ff[1][G-1:0]};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      num_in   = num_ff;
      pos_in   = pos_ff;
      nz_in    = nz_ff;
      scell_in = scell_ff;
      fin_in   = fin_ff;
      cell_in  = cell_ff;
      d2_in    = d2_ff;
      msq_in   = msq_ff;
      c01_in   = c01_ff;
      c02_in   = c02_ff;
      c12_in   = c12_ff;
      rsp_in   = '0;
      rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i]   = (pt_e[i] >= pt_s[i]) ? (pt_e[i] - pt_s[i])
                                                     : (pt_s[i] - pt_e[i]);
                  pos_in[i]   = pt_e[i] > pt_s[i];
                  nz_in[i]    = pt_e[i] != pt_s[i];
                  scell_in[i] = pt_s[i][CB-1:F];
                  fin_in[i]   = pt_e[i][CB-1:F];
                  cell_in[i]  = {2'b00, pt_s[i][CB-1:F]};
                  num_in[i]   = (pt_e[i] > pt_s[i]) ? (ONE - NW'(pt_s[i][F-1:0]))
                                                    : NW'(pt_s[i][F-1:0]);
               end
               cnt_in   = P_SQX;
               d2_in    = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 4'd1;
            if (pv_ff) begin
               case (tag_ff)
                  P_SQX, P_SQY, P_SQZ: d2_in = d2_ff + SW'(prod_ff);
                  P_MAX:  msq_in = prod_ff;
                  P_N0M1: c01_in = prod_s;
                  P_N1M0: c01_in = c01_ff - prod_s;
                  P_N0M2: c02_in = prod_s;
                  P_N2M0: c02_in = c02_ff - prod_s;
                  P_N1M2: c12_in = prod_s;
                  P_N2M1: c12_in = c12_ff - prod_s;
                  default: d2_in = d2_ff;
               endcase
            end
            if (cnt_ff == P_DONE) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (d2_ff == '0) begin
               rsp_in   = '{valid: 1'b1, visible: 1'b1};
               state_in = ST_IDLE;
            end else if (d2_ff > SW'(msq_ff)) begin
               rsp_in   = '{valid: 1'b1, visible: 1'b0};
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (at_end) begin
               rsp_in   = '{valid: 1'b1, visible: 1'b1};
               state_in = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (blocked) begin
               rsp_in   = '{valid: 1'b1, visible: 1'b0};
               state_in = ST_IDLE;
            end else begin
               num_in[ax] = n_sel + ONE;
               if (pos_ff[ax]) begin
                  cell_in[ax] = cell_ff[ax] + CLW'(1);
               end else if (nz_ff[ax]) begin
                  cell_in[ax] = cell_ff[ax] - CLW'(1);
               end
               // keep cross products exact as the chosen numerator grows
               case (ax)
                  2'd0: begin
                     c01_in = c01_ff + $signed(shm[1]);
                     c02_in = c02_ff + $signed(shm[2]);
                  end
                  2'd1: begin
                     c01_in = c01_ff - $signed(shm[0]);
                     c12_in = c12_ff + $signed(shm[2]);
                  end
                  default: begin
                     c02_in = c02_ff - $signed(shm[0]);
                     c12_in = c12_ff - $signed(shm[1]);
                  end
               endcase
               if (n_sel > {1'b0, m_sel}) begin
                  rsp_in   = '{valid: 1'b1, visible: 1'b1};
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_ff   <= '0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
         pv_ff    <= (state_ff == ST_MUL);
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      tag_ff   <= cnt_ff;
      prod_ff  <= mul_a * mul_b;
      mag_ff   <= mag_in;
      num_ff   <= num_in;
      pos_ff   <= pos_in;
      nz_ff    <= nz_in;
      scell_ff <= scell_in;
      fin_ff   <= fin_in;
      cell_ff  <= cell_in;
      d2_ff    <= d2_in;
      msq_ff   <= msq_in;
      c01_ff   <= c01_in;
      c02_ff   <= c02_in;
      c12_ff   <= c12_in;
   end

   assign rsp = rsp_ff;

endmodule

// File: rtl/core/voxel_line_of_sight.sv
// ----------------------------------------------------------------------------
// voxel_line_of_sight
// occupancy bitmap of a cubic voxel grid with a line-of-sight query
// ----------------------------------------------------------------------------
// usage
//   request channel: a request is taken at a clock edge with start high and
//   busy low. req_type selects a cell write (req_cell_*, req_solid) or a
//   query from req_start_* to req_end_* (unsigned fixed point)
//   result channel: a query gives one rsp_valid pulse with rsp_visible; a
//   write gives nothing. the receiver cannot stall, so results never wait
//   csr port: csr_wr_en with csr_wr_data sets the view range, any time the
//   block is idle
//   a write holds busy through a row read and a row write back, and the
//   next request can be taken once the block is idle again
//   a query runs its setup first: the squared deltas and range and the cross
//   products on the one shared multiplier, then one range compare; a zero
//   length or out of range query answers after setup, a walk after one end
//   check and one occupancy row read per cell stepped, until a solid cell,
//   the end cell or the end crossing stops it; busy drops after the result,
//   one request is worked at a time
//   reset: the bitmap is swept clear one row per cycle, 4^GRID_BITS rows
//   (1024 at the default), with busy high; the view range goes to 4096
// ----------------------------------------------------------------------------
module voxel_line_of_sight #(
   parameter int unsigned GRID_BITS = 5,
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [GRID_BITS-1:0]               req_cell_x,
   input  logic [GRID_BITS-1:0]               req_cell_y,
   input  logic [GRID_BITS-1:0]               req_cell_z,
   input  logic                               req_solid,
   input  logic [GRID_BITS+FRAC_BITS-1:0]     req_start_x,
   input  logic [GRID_BITS+FRAC_BITS-1:0]     req_start_y,
   input  logic [GRID_BITS+FRAC_BITS-1:0]     req_start_z,
   input  logic [GRID_BITS+FRAC_BITS-1:0]     req_end_x,
   input  logic [GRID_BITS+FRAC_BITS-1:0]     req_end_y,
   input  logic [GRID_BITS+FRAC_BITS-1:0]     req_end_z,
   output logic                               rsp_valid,
   output logic                               rsp_visible,
   input  logic                               csr_wr_en,
   input  logic [vls_pkg::DIST_W-1:0]         csr_wr_data
);

   localparam int unsigned SIDE = 1 << GRID_BITS;
   localparam int unsigned RW   = 2 * GRID_BITS;

   // top level sequencer states
   localparam logic [2:0] T_CLEAR = 3'd0;
   localparam logic [2:0] T_IDLE  = 3'd1;
   localparam logic [2:0] T_WRD   = 3'd2;
   localparam logic [2:0] T_WWR   = 3'd3;
   localparam logic [2:0] T_QRY   = 3'd4;

   logic [2:0] state_ff, state_in;

   logic [vls_pkg::DIST_W-1:0] max_dist_ff;

   // latched write request
   logic [RW-1:0]        wrow_ff;
   logic [GRID_BITS-1:0] wx_ff;
   logic                 wsolid_ff;

   logic accept, go_query, go_write;

   // memory port
   logic            mem_rd_en, mem_wr_en, mem_ready;
   logic [RW-1:0]   mem_rd_row;
   logic [SIDE-1:0] mem_rd_data, mem_wr_data;

   // tracer
   logic                 trc_rd_en;
   logic [RW-1:0]        trc_rd_row;
   vls_pkg::vls_rsp_type trc_rsp;

   assign busy     = (state_ff != T_IDLE);
   assign accept   = start && !busy;
   assign go_query = accept && (req_type == vls_pkg::REQ_QUERY);
   assign go_write = accept && (req_type == vls_pkg::REQ_WRITE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_CLEAR: if (mem_ready) state_in = T_IDLE;
         T_IDLE: begin
            if (go_write) begin
               state_in = T_WRD;
            end else if (go_query) begin
               state_in = T_QRY;
            end
         end
         T_WRD:   state_in = T_WWR;
         T_WWR:   state_in = T_IDLE;
         T_QRY:   if (trc_rsp.valid) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= T_CLEAR;
         max_dist_ff <= vls_pkg::DIST_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            max_dist_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go_write) begin
         wrow_ff   <= {req_cell_z, req_cell_y};
         wx_ff     <= req_cell_x;
         wsolid_ff <= req_solid;
      end
   end

   // write requests read the row, patch one bit and write it back
   always_comb begin
      mem_wr_data        = mem_rd_data;
      mem_wr_data[wx_ff] = wsolid_ff;
   end

   assign mem_rd_en  = (state_ff == T_WRD) || trc_rd_en;
   assign mem_rd_row = (state_ff == T_WRD) ? wrow_ff : trc_rd_row;
   assign mem_wr_en  = (state_ff == T_WWR);

   vls_occ_mem #(
      .G (GRID_BITS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_row  (mem_rd_row),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_row  (wrow_ff),
      .wr_data (mem_wr_data),
      .ready   (mem_ready)
   );

   vls_tracer #(
      .G (GRID_BITS),
      .F (FRAC_BITS)
   ) u_tracer (
      .clock    (clock),
      .reset    (reset),
      .go       (go_query),
      .pt_s     ({req_start_z, req_start_y, req_start_x}),
      .pt_e     ({req_end_z, req_end_y, req_end_x}),
      .max_dist (max_dist_ff),
      .rd_en    (trc_rd_en),
      .rd_row   (trc_rd_row),
      .rd_data  (mem_rd_data),
      .rsp      (trc_rsp)
   );

   assign rsp_valid   = trc_rsp.valid;
   assign rsp_visible = trc_rsp.visible;

   // results only come out of a running query
   a_rsp_in_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == T_QRY))
      else $error("result outside a query");

   // an accepted write goes to the row read next
   a_write_seq: assert property (@(posedge clock) disable iff (reset)
      go_write |=> (state_ff == T_WRD))
      else $error("write request not sequenced");

   // row read is always followed by its write back
   a_rmw: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_WRD) |=> (state_ff == T_WWR))
      else $error("read-modify-write broken");

   // no request is taken before the clear pass ends
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      !mem_ready |-> busy)
      else $error("idle during clear pass");

   // memory is not shared between a write and a tracer read
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      trc_rd_en |-> (state_ff == T_QRY))
      else $error("tracer read outside a query");

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench for voxel_line_of_sight: cell writes and line-of-sight queries
// against an in-bench occupancy map and exact 3D grid walk
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GB  = 5;
   localparam int FB  = 8;
   localparam int CW  = GB + FB;
   localparam int ONE = 1 << FB;
   localparam int COORD_MAX = (1 << CW) - 1;
   localparam int WATCHDOG_LIMIT = 20000;

   // one request as the sender sees it; axis 0 is x, 1 is y, 2 is z
   typedef struct packed {
      logic                  kind;
      logic [2:0][GB-1:0]    vox;
      logic                  solid;
      logic [2:0][CW-1:0]    from;
      logic [2:0][CW-1:0]    to;
   } request_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_type = vls_pkg::REQ_WRITE;
   logic [GB-1:0]     req_cell_x = '0, req_cell_y = '0, req_cell_z = '0;
   logic              req_solid = 1'b0;
   logic [CW-1:0]     req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic [CW-1:0]     req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic              rsp_valid;
   logic              rsp_visible;
   logic              csr_wr_en = 1'b0;
   logic [vls_pkg::DIST_W-1:0] csr_wr_data = '0;

   // predictor state: occupancy map and view range
   logic              solid_map [0:(1<<(3*GB))-1];
   logic [vls_pkg::DIST_W-1:0] view_range = vls_pkg::DIST_RESET;
   logic              visible_q [$];

   int mismatches = 0;
   int n_writes = 0, n_queries = 0, n_seen = 0, n_visible = 0;
   int burst_left = 1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   voxel_line_of_sight #(.GRID_BITS(GB), .FRAC_BITS(FB)) dut (.*);

   // ------------------------------------------------------------------------
   // predictor: exact grid walk from start point to end point
   // ------------------------------------------------------------------------
   function automatic logic map_solid(int c[3]);
      for (int i = 0; i < 3; i++)
         if (c[i] < 0 || c[i] > (1 << GB) - 1) return 1'b0;  // outside grid is open
      return solid_map[(c[2] << (2*GB)) | (c[1] << GB) | c[0]];
   endfunction

   // crossing of axis i strictly earlier than crossing of axis j
   function automatic logic earlier(longint unsigned num[3], longint unsigned mag[3],
                                    int i, int j);
      if (mag[i] == 0) return 1'b0;
      if (mag[j] == 0) return 1'b1;
      return num[i] * mag[j] < num[j] * mag[i];
   endfunction

   function automatic logic sight_clear(request_type r);
      longint unsigned mag[3], num[3];
      longint unsigned d2, n, range;
      int cur[3], org[3], fin[3], stp[3];
      int a, s, e;
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
         s = int'(r.from[i]);
         e = int'(r.to[i]);
         mag[i] = (e >= s) ? longint'(e - s) : longint'(s - e);
         d2 += mag[i] * mag[i];
         org[i] = s >> FB;
         fin[i] = e >> FB;
         cur[i] = org[i];
         stp[i] = (e > s) ? 1 : ((e < s) ? -1 : 0);
         // distance to first boundary; zero when leaving a boundary backward
         num[i] = (stp[i] > 0) ? longint'(ONE - (s % ONE)) : longint'(s % ONE);
      end
      range = longint'(view_range);
      if (d2 == 0) return 1'b1;
      if (d2 > range * range) return 1'b0;
      while (1) begin
         if (cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]) return 1'b1;
         if (!(cur[0] == org[0] && cur[1] == org[1] && cur[2] == org[2])
             && map_solid(cur)) return 1'b0;
         // ties go to the later axis
         if (earlier(num, mag, 0, 1) && earlier(num, mag, 0, 2)) a = 0;
         else if (earlier(num, mag, 1, 2)) a = 1;
         else a = 2;
         n = num[a];
         cur[a] += stp[a];
         num[a] += ONE;
         if (n > mag[a]) return 1'b1;  // crossed past the end point
      end
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_request(request_type r);
      int gap;
      start       <= 1'b1;
      req_type    <= r.kind;
      req_cell_x  <= r.vox[0];
      req_cell_y  <= r.vox[1];
      req_cell_z  <= r.vox[2];
      req_solid   <= r.solid;
      req_start_x <= r.from[0];
      req_start_y <= r.from[1];
      req_start_z <= r.from[2];
      req_end_x   <= r.to[0];
      req_end_y   <= r.to[1];
      req_end_z   <= r.to[2];
      // busy read here is its value before this edge, as the block saw it
      do @(posedge clock); while (busy);
      if (r.kind == vls_pkg::REQ_WRITE) begin
         solid_map[{r.vox[2], r.vox[1], r.vox[0]}] = r.solid;
         n_writes++;
      end else begin
         visible_q = {visible_q, sight_clear(r)};
         n_queries++;
      end
      // bursts of back-to-back requests, then sometimes an idle gap
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // wait until the block has gone quiet with nothing outstanding
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (visible_q.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_range(logic [vls_pkg::DIST_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      view_range = v;
      @(posedge clock);
   endtask

   function automatic request_type cell_write(int x, int y, int z, logic s);
      request_type r;
      r = '0;
      r.kind = vls_pkg::REQ_WRITE;
      r.vox[0] = GB'(x); r.vox[1] = GB'(y); r.vox[2] = GB'(z);
      r.solid = s;
      r.from = {3{CW'($urandom)}};  // unused by writes, keep them busy
      r.to = {3{CW'($urandom)}};
      return r;
   endfunction

   function automatic request_type query(int sx, int sy, int sz, int ex, int ey, int ez);
      request_type r;
      r = '0;
      r.kind = vls_pkg::REQ_QUERY;
      r.vox = {3{GB'($urandom)}};
      r.solid = 1'($urandom);
      r.from[0] = CW'(sx); r.from[1] = CW'(sy); r.from[2] = CW'(sz);
      r.to[0] = CW'(ex); r.to[1] = CW'(ey); r.to[2] = CW'(ez);
      return r;
   endfunction

   function automatic int clamp_coord(int v);
      return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   // random request: writes mostly clustered in a box, queries mostly through it
   function automatic request_type random_request(int lo, int span, int reach);
      int p[3], q[3];
      if ($urandom_range(0, 99) < 40) begin
         if ($urandom_range(0, 9) == 0)
            return cell_write($urandom, $urandom, $urandom, 1'($urandom));
         return cell_write(lo + $urandom_range(0, span), lo + $urandom_range(0, span),
                           lo + $urandom_range(0, span), $urandom_range(0, 3) != 0);
      end
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 9))
            0: p[i] = $urandom_range(0, COORD_MAX);
            1: p[i] = (lo + $urandom_range(0, span)) * ONE;  // on a boundary
            default: p[i] = (lo + $urandom_range(0, span)) * ONE + $urandom_range(0, ONE - 1);
         endcase
         case ($urandom_range(0, 9))
            0: q[i] = $urandom_range(0, COORD_MAX);
            1: q[i] = p[i];
            default: q[i] = clamp_coord(p[i] + $urandom_range(0, 2 * reach) - reach);
         endcase
      end
      return query(p[0], p[1], p[2], q[0], q[1], q[2]);
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   task automatic note_mismatch(string what, logic want, logic got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d: %s, expected visible=%0b got %0b at %0t",
                  mismatches, what, want, got, $realtime);
   endtask

   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_valid) begin
         n_seen++;
         if (visible_q.size() == 0) begin
            note_mismatch("result with no request outstanding", 1'bx, rsp_visible);
         end else begin
            want = visible_q.pop_front();
            if (rsp_visible !== want) note_mismatch("wrong answer", want, rsp_visible);
            if (want) n_visible++;
         end
      end
   end

   // watchdog: cycles with neither a request taken nor a result given
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", visible_q.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      // zero length and the far corners
      send_request(query(1234, 4321, 8191, 1234, 4321, 8191));
      send_request(query(0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX));
      send_request(query(COORD_MAX, 0, COORD_MAX, 0, COORD_MAX, 0));
      // range limit: exactly at it, one past it
      send_request(query(0, 100, 100, 4096, 100, 100));
      send_request(query(0, 100, 100, 4097, 100, 100));
      // one solid cell on an x line
      send_request(cell_write(5, 5, 5, 1'b1));
      send_request(query(3*ONE + 128, 5*ONE + 128, 5*ONE + 128,
                         8*ONE + 128, 5*ONE + 128, 5*ONE + 128));
      // start inside the solid cell does not block
      send_request(query(5*ONE + 128, 5*ONE + 128, 5*ONE + 128,
                         8*ONE + 128, 5*ONE + 128, 5*ONE + 128));
      // end inside the solid cell is still seen
      send_request(query(2*ONE + 10, 5*ONE + 128, 5*ONE + 128,
                         5*ONE + 200, 5*ONE + 128, 5*ONE + 128));
      // negative walk starting exactly on a boundary
      send_request(query(6*ONE, 5*ONE + 128, 5*ONE, 2*ONE + 10, 5*ONE + 128, 5*ONE));
      send_request(query(6*ONE, 6*ONE, 6*ONE, 4*ONE, 4*ONE, 4*ONE));
      // exact diagonal ties, blocker on the y-first path
      send_request(cell_write(3, 4, 5, 1'b1));
      send_request(query(3*ONE + 128, 3*ONE + 128, 5*ONE + 128,
                         6*ONE + 128, 6*ONE + 128, 5*ONE + 128));
      send_request(query(3*ONE + 128, 3*ONE + 128, 3*ONE + 128,
                         6*ONE + 128, 6*ONE + 128, 6*ONE + 128));
      // clear both and repeat
      send_request(cell_write(5, 5, 5, 1'b0));
      send_request(cell_write(3, 4, 5, 1'b0));
      send_request(query(3*ONE + 128, 5*ONE + 128, 5*ONE + 128,
                         8*ONE + 128, 5*ONE + 128, 5*ONE + 128));
      send_request(query(3*ONE + 128, 3*ONE + 128, 5*ONE + 128,
                         6*ONE + 128, 6*ONE + 128, 5*ONE + 128));
      // top corner of the grid, walk toward it and past the end
      send_request(cell_write(31, 31, 31, 1'b1));
      send_request(cell_write(0, 0, 0, 1'b1));
      send_request(query(28*ONE, 28*ONE, 28*ONE, COORD_MAX, COORD_MAX, COORD_MAX - 300));
      send_request(query(ONE + 5, ONE + 5, ONE + 5, 0, 0, 0));
      send_request(query(3*ONE, 0, 0, 0, 255, 0));
   endtask

   task automatic test_random(int count, int reach);
      int lo, span;
      for (int k = 0; k < count; k++) begin
         if (k % 60 == 0) begin
            span = $urandom_range(2, 9);
            lo = $urandom_range(0, 31 - span);
         end
         send_request(random_request(lo, span, reach));
      end
   endtask

   task automatic test_range_settings();
      set_range(14'd0);          // every nonzero ray is out of range
      test_random(40, 4 * ONE);
      set_range(14'd16383);      // longest range, long walks
      test_random(220, 20 * ONE);
      set_range(vls_pkg::DIST_W'($urandom_range(256, 3000)));
      test_random(180, 8 * ONE);
      set_range(vls_pkg::DIST_RESET);
      test_random(120, 6 * ONE);
   endtask

   initial begin
      foreach (solid_map[i]) solid_map[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(240, 6 * ONE);  // reset view range
      test_range_settings();
      drain();
      $display("covered %0d cell writes and %0d queries over five view ranges",
               n_writes, n_queries);
      $display("%0d results checked, %0d of them visible", n_seen, n_visible);
      if (mismatches == 0 && visible_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, visible_q.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/vls_pkg.sv
rtl/core/vls_occ_mem.sv
rtl/core/vls_tracer.sv
rtl/core/voxel_line_of_sight.sv
dv/tb.sv
